/* src/atimer_pkg.sv */
`default_nettype none

package atimer_pkg;

  // default number of timer slots
  localparam int unsigned SlotsDef = 8;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SlotFW = 3;
  localparam int unsigned EventW = 8;

  // wide enough to compare a slot field against any slot count up to 127
  localparam int unsigned SlotCmpW = 7;

  typedef enum logic [CmdW-1:0] {
    CmdCheck = 2'd0,
    CmdArm   = 2'd1,
    CmdQuery = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [TimeW-1:0]  now_ms;
    logic [SlotFW-1:0] slot;
    logic [EventW-1:0] event_id;
    logic [TimeW-1:0]  reload_interval;
    logic [TimeW-1:0]  due_time;
    logic              enable;
  } in_t;

  typedef struct packed {
    logic [EventW-1:0] fired_event;
    logic [TimeW-1:0]  remaining_ms;
  } out_t;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic [TimeW-1:0]  due;
    logic [TimeW-1:0]  interval;
    logic [EventW-1:0] event_id;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

`default_nettype wire

/* src/alert_timer_table.sv */
// alert_timer_table: table of alert timers with arm, check and query transactions
// sequence: arm and unused codes go from idle straight to the done state;
//   check and query scan the table first, one slot compared per cycle
// throughput: one transaction at a time; the slot memory read port and the single
//   33-bit subtractor walk the table in index order, stopping at the first hit
// reset: asynchronous, active low; clears all enable bits, the sequencer and output valid
`default_nettype none

module alert_timer_table #(
  parameter int unsigned SLOTS = atimer_pkg::SlotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  atimer_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output atimer_pkg::out_t out_data_o
);

  import atimer_pkg::*;

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW  = SlotW + 1;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StWb   = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // latched transaction fields used during the scan
  logic [CmdW-1:0]   cmd_q;
  logic [TimeW-1:0]  now_q;
  logic [EventW-1:0] id_q;

  // scan pointers: idx_q is the address being read, cmp_idx_q the entry being compared
  logic [CntW-1:0]   idx_q;
  logic [SlotW-1:0]  cmp_idx_q;
  logic              cmp_vld_q;

  // per-slot enable bits, the only table state that reset defines
  logic [SLOTS-1:0]  en_q;

  // writeback of a periodic slot that fired
  logic [SlotW-1:0]  wb_idx_q;
  logic [TimeW-1:0]  wb_ival_q;
  logic [EventW-1:0] wb_event_q;

  out_t              res_q;
  logic              out_valid_q;
  out_t              out_data_q;

  logic                accept;
  logic [SlotCmpW-1:0] slot_wide;
  logic                arm_ok;
  logic [SlotW-1:0]    arm_addr;
  logic                issue;
  logic                out_free;

  logic                ram_we;
  logic [SlotW-1:0]    ram_waddr;
  entry_t              ram_wdata;
  entry_t              rd_entry;

  logic [TimeW:0]      diff;
  logic                late;
  logic                due_le;
  logic                cur_en;
  logic                hit;
  logic                is_check;

  // handshake: one transaction in flight, the output register parts the two sides
  assign accept      = in_valid_i && (state_q == StIdle);
  assign in_stall_o  = (state_q != StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // arm addressing; slot numbers at or above SLOTS are dropped
  assign slot_wide = SlotCmpW'(in_data_i.slot);
  assign arm_ok    = (slot_wide < SlotCmpW'(SLOTS));
  assign arm_addr  = slot_wide[SlotW-1:0];

  // read one slot per cycle until the pointer runs off the table
  assign issue = (state_q == StScan) && (idx_q < CntW'(SLOTS));

  // shared subtractor: due - now gives both the due test and the remaining time
  assign diff   = {1'b0, rd_entry.due} - {1'b0, now_q};
  assign late   = diff[TimeW];
  assign due_le = late || (diff[TimeW-1:0] == '0);

  assign is_check = (cmd_q == CmdCheck);
  assign cur_en   = en_q[cmp_idx_q];
  assign hit      = cmp_vld_q && cur_en &&
                    (is_check ? due_le : (rd_entry.event_id == id_q));

  // single write port: arm at acceptance, reschedule in the writeback state
  always_comb begin
    if (state_q == StWb) begin
      ram_we             = 1'b1;
      ram_waddr          = wb_idx_q;
      ram_wdata.due      = now_q + wb_ival_q;
      ram_wdata.interval = wb_ival_q;
      ram_wdata.event_id = wb_event_q;
    end else begin
      ram_we             = accept && (in_data_i.cmd == CmdArm) && arm_ok;
      ram_waddr          = arm_addr;
      ram_wdata.due      = in_data_i.due_time;
      ram_wdata.interval = in_data_i.reload_interval;
      ram_wdata.event_id = in_data_i.event_id;
    end
  end

  atimer_ram #(
    .Width (EntryW),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[SlotW-1:0]),
    .rdata_o (rd_entry)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if ((in_data_i.cmd == CmdCheck) || (in_data_i.cmd == CmdQuery)) begin
            state_d = StScan;
          end else begin
            state_d = StDone;
          end
        end
      end
      StScan: begin
        if (hit) begin
          // a periodic slot that fired needs its due time rewritten
          if (is_check && (rd_entry.interval != '0)) begin
            state_d = StWb;
          end else begin
            state_d = StDone;
          end
        end else if (cmp_vld_q && !issue) begin
          // last slot compared, nothing found
          state_d = StDone;
        end
      end
      StWb: begin
        state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      en_q        <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= issue;
      if (accept && (in_data_i.cmd == CmdArm) && arm_ok) begin
        en_q[arm_addr] <= in_data_i.enable;
      end else if ((state_q == StScan) && hit && is_check &&
                   (rd_entry.interval == '0)) begin
        // one-shot slot retires when it fires
        en_q[cmp_idx_q] <= 1'b0;
      end
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_data_i.cmd;
      now_q <= in_data_i.now_ms;
      id_q  <= in_data_i.event_id;
      idx_q <= '0;
      res_q <= '0;
    end else if (state_q == StScan) begin
      idx_q     <= idx_q + CntW'(issue);
      cmp_idx_q <= idx_q[SlotW-1:0];
      if (hit) begin
        if (is_check) begin
          res_q.fired_event <= rd_entry.event_id;
        end else begin
          res_q.remaining_ms <= late ? '0 : diff[TimeW-1:0];
        end
        wb_idx_q   <= cmp_idx_q;
        wb_ival_q  <= rd_entry.interval;
        wb_event_q <= rd_entry.event_id;
      end
    end
    if ((state_q == StDone) && out_free) begin
      out_data_q <= res_q;
    end
  end

endmodule

`default_nettype wire

/* src/atimer_ram.sv */
`default_nettype none

module atimer_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/atimer_chk.sv */
`default_nettype none

module atimer_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input atimer_pkg::out_t out_data_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // one transaction at a time: busy right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  // a new result only appears at the end of a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction in flight");

  // going ready again always comes with a result on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("transaction finished without a result");

endmodule

bind alert_timer_table atimer_chk u_atimer_chk (.*);

`default_nettype wire
